// ===== src/minmax_peak_decimator_defines.svh =====
// assertion macros for the min/max peak decimator
// no dependencies; included by the top level only
`ifndef MINMAX_PEAK_DECIMATOR_DEFINES_SVH
`define MINMAX_PEAK_DECIMATOR_DEFINES_SVH

// condition holds at every clock edge out of reset
`define MMPD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define MMPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mmpd_pkg.sv =====
// shared types, constants and helper functions of the min/max peak decimator
// no dependencies; used by mmpd_quant and minmax_peak_decimator
`default_nettype none

package mmpd_pkg;

    localparam logic [16:0] MAX_BLOCKS = 17'd65536;
    localparam logic [13:0] MAX_TEXELS = 14'd8192;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_VISIBLE_BLOCKS = 1'b0,
        CFG_TEXEL_COUNT    = 1'b1
    } cfg_index_t;

    // running group values
    typedef struct packed {
        logic signed [15:0] min;
        logic signed [15:0] max;
        logic [15:0]        low;
        logic [15:0]        mid;
        logic [15:0]        high;
    } run_vals_t;

    // quantized texel bytes
    typedef struct packed {
        logic [7:0] min;
        logic [7:0] max;
        logic [7:0] low;
        logic [7:0] mid;
        logic [7:0] high;
    } texel_bytes_t;

    localparam run_vals_t RUN_RESET = '{
        min:  16'sh7FFF,
        max:  16'sh8000,
        low:  16'h0000,
        mid:  16'h0000,
        high: 16'h0000
    };

    // blocks per window clamped to 1..MAX_BLOCKS
    function automatic logic [16:0] eff_visible(input logic [16:0] raw);
        logic [16:0] v;
        v = raw;
        if (v == 17'd0) begin
            v = 17'd1;
        end
        if (v > MAX_BLOCKS) begin
            v = MAX_BLOCKS;
        end
        return v;
    endfunction

    // texels per window clamped to 1..MAX_TEXELS, then saturated to the block count
    function automatic logic [13:0] eff_texels(input logic [13:0] raw,
                                               input logic [16:0] vis);
        logic [13:0] t;
        t = raw;
        if (t == 14'd0) begin
            t = 14'd1;
        end
        if (t > MAX_TEXELS) begin
            t = MAX_TEXELS;
        end
        if ({3'b000, t} > vis) begin
            t = vis[13:0];
        end
        return t;
    endfunction

    // floor((u * 255 + 32768) / 65536), never above 255
    function automatic logic [7:0] quant8(input logic [15:0] u);
        logic [23:0] p;
        p = {u, 8'h00} - {8'h00, u} + 24'd32768;
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== src/mmpd_quant.sv =====
// byte quantizer for one texel: amplitudes mapped -1..1 onto 0..255, energies scaled
// depends on mmpd_pkg
`default_nettype none

module mmpd_quant (
    input  wire mmpd_pkg::run_vals_t    run_i,
    output mmpd_pkg::texel_bytes_t      bytes_o
);

    // adding 32768 to a signed 16-bit value flips its sign bit
    always_comb begin
        bytes_o.min  = mmpd_pkg::quant8({~run_i.min[15], run_i.min[14:0]});
        bytes_o.max  = mmpd_pkg::quant8({~run_i.max[15], run_i.max[14:0]});
        bytes_o.low  = mmpd_pkg::quant8(run_i.low);
        bytes_o.mid  = mmpd_pkg::quant8(run_i.mid);
        bytes_o.high = mmpd_pkg::quant8(run_i.high);
    end

endmodule

`default_nettype wire

// ===== src/minmax_peak_decimator.sv =====
// min/max peak-detect decimator, top level
// depends on mmpd_pkg, mmpd_quant and minmax_peak_decimator_defines.svh
// usage:
//   s_ channel: one analysis block per request (min/max amplitude, three band
//   energies, window_start flag). s_window_start restarts the window first.
//   m_ channel: one texel per closed group, with its index and a last flag.
//   cfg channel: cfg_index selects visible_blocks or texel_count, cfg_data
//   carries the value; a write restarts the window. cfg_ready is always high.
// timing:
//   one block per cycle while s_ready is high. a block is folded into the running
//   group in the cycle it is taken; when it closes the group the texel is on m_
//   from the cycle after that edge. the output register lets the next block in
//   while a texel waits, so s_ready only drops when a texel is held and
//   m_ready is low (the output register is the only buffer).
// window bookkeeping:
//   group ends are found with an error accumulator, no divider. after the
//   last texel of a window further blocks are dropped until window_start or a cfg write.
// reset:
//   both registers return to 1, the window restarts empty, no texel pending.
`default_nettype none

`include "minmax_peak_decimator_defines.svh"

module minmax_peak_decimator (
    input  wire                aclk,
    input  wire                aresetn,

    // configuration writes
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [0:0]         cfg_index,
    input  wire  [16:0]        cfg_data,

    // analysis block requests
    input  wire                s_valid,
    output logic               s_ready,
    input  wire                s_window_start,
    input  wire signed [15:0]  s_min_value,
    input  wire signed [15:0]  s_max_value,
    input  wire  [15:0]        s_low_energy,
    input  wire  [15:0]        s_mid_energy,
    input  wire  [15:0]        s_high_energy,

    // texel results
    output logic               m_valid,
    input  wire                m_ready,
    output logic [12:0]        m_texel_index,
    output logic [7:0]         m_min_byte,
    output logic [7:0]         m_max_byte,
    output logic [7:0]         m_low_byte,
    output logic [7:0]         m_mid_byte,
    output logic [7:0]         m_high_byte,
    output logic               m_last_texel
);

    // configuration: raw register values and their clamped forms
    logic [16:0] vis_raw_reg, vis_raw_next;
    logic [13:0] tex_raw_reg, tex_raw_next;
    logic [16:0] v_eff_reg,   v_eff_next;
    logic [13:0] t_eff_reg,   t_eff_next;

    // window state
    logic [15:0]         err_reg, err_next;   // stays below the block count
    logic [12:0]         cnt_reg, cnt_next;
    logic                done_reg, done_next;
    mmpd_pkg::run_vals_t run_reg, run_next;

    // output stage
    logic                m_valid_reg, m_valid_next;
    logic [12:0]         idx_reg;
    mmpd_pkg::texel_bytes_t bytes_reg;
    logic                last_reg;

    logic cfg_fire;
    logic s_fire;

    // per-request working values
    logic [15:0]         restart_err;
    logic [15:0]         err_base;
    logic [12:0]         cnt_base;
    logic                done_base;
    mmpd_pkg::run_vals_t run_base;
    mmpd_pkg::run_vals_t run_merge;
    logic                group_close;
    logic                emit_last;
    logic                emit;
    logic [17:0]         err_wrap;
    logic [15:0]         err_step;
    logic [16:0]         cfg_err;
    logic [16:0]         win_err;
    mmpd_pkg::texel_bytes_t quant_bytes;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    // register write decode, clamping recomputed from the values being written
    always_comb begin
        vis_raw_next = vis_raw_reg;
        tex_raw_next = tex_raw_reg;
        if (cfg_fire) begin
            unique case (mmpd_pkg::cfg_index_t'(cfg_index))
                mmpd_pkg::CFG_VISIBLE_BLOCKS: vis_raw_next = cfg_data;
                mmpd_pkg::CFG_TEXEL_COUNT:    tex_raw_next = cfg_data[13:0];
                default:                      vis_raw_next = vis_raw_reg;
            endcase
        end
        v_eff_next = mmpd_pkg::eff_visible(vis_raw_next);
        t_eff_next = mmpd_pkg::eff_texels(tex_raw_next, v_eff_next);
    end

    // error accumulator start value, V - T always fits in 16 bits
    assign win_err     = v_eff_reg - {3'b000, t_eff_reg};
    assign restart_err = win_err[15:0];
    assign cfg_err     = v_eff_next - {3'b000, t_eff_next};

    // window_start clears everything before the block is folded in
    always_comb begin
        if (s_window_start) begin
            err_base  = restart_err;
            cnt_base  = 13'd0;
            done_base = 1'b0;
            run_base  = mmpd_pkg::RUN_RESET;
        end else begin
            err_base  = err_reg;
            cnt_base  = cnt_reg;
            done_base = done_reg;
            run_base  = run_reg;
        end
    end

    // fold the block into the running group
    always_comb begin
        run_merge = run_base;
        if (s_min_value < run_base.min) begin
            run_merge.min = s_min_value;
        end
        if (s_max_value > run_base.max) begin
            run_merge.max = s_max_value;
        end
        if (s_low_energy > run_base.low) begin
            run_merge.low = s_low_energy;
        end
        if (s_mid_energy > run_base.mid) begin
            run_merge.mid = s_mid_energy;
        end
        if (s_high_energy > run_base.high) begin
            run_merge.high = s_high_energy;
        end
    end

    // group boundary: the block closes its group when the error is below T
    assign group_close = err_base < {2'b00, t_eff_reg};
    assign emit_last   = ({1'b0, cnt_base} + 14'd1) >= t_eff_reg;
    assign emit        = s_fire && !cfg_fire && !done_base && group_close;
    assign err_wrap    = {2'b00, err_base} + {1'b0, v_eff_reg} - {4'h0, t_eff_reg};
    assign err_step    = err_base - {2'b00, t_eff_reg};

    mmpd_quant u_quant (
        .run_i   (run_merge),
        .bytes_o (quant_bytes)
    );

    // window state update; a configuration write restarts the window
    always_comb begin
        err_next  = err_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        run_next  = run_reg;
        if (cfg_fire) begin
            err_next  = cfg_err[15:0];
            cnt_next  = 13'd0;
            done_next = 1'b0;
            run_next  = mmpd_pkg::RUN_RESET;
        end else if (s_fire) begin
            err_next  = err_base;
            cnt_next  = cnt_base;
            done_next = done_base;
            run_next  = run_base;
            if (!done_base) begin
                if (group_close) begin
                    // texel goes out, group starts over
                    err_next  = err_wrap[15:0];
                    cnt_next  = cnt_base + 13'd1;
                    done_next = emit_last;
                    run_next  = mmpd_pkg::RUN_RESET;
                end else begin
                    err_next  = err_step;
                    run_next  = run_merge;
                end
            end
        end
    end

    // output register: loaded on a closing block, cleared once taken
    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_raw_reg <= 17'd1;
            tex_raw_reg <= 14'd1;
            v_eff_reg   <= 17'd1;
            t_eff_reg   <= 14'd1;
            err_reg     <= 16'd0;
            cnt_reg     <= 13'd0;
            done_reg    <= 1'b0;
            run_reg     <= mmpd_pkg::RUN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            vis_raw_reg <= vis_raw_next;
            tex_raw_reg <= tex_raw_next;
            v_eff_reg   <= v_eff_next;
            t_eff_reg   <= t_eff_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // texel payload, no reset needed
    always_ff @(posedge aclk) begin
        if (emit) begin
            idx_reg   <= cnt_base;
            bytes_reg <= quant_bytes;
            last_reg  <= emit_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_texel_index = idx_reg;
    assign m_min_byte    = bytes_reg.min;
    assign m_max_byte    = bytes_reg.max;
    assign m_low_byte    = bytes_reg.low;
    assign m_mid_byte    = bytes_reg.mid;
    assign m_high_byte   = bytes_reg.high;
    assign m_last_texel  = last_reg;

    // checks on the window bookkeeping
    `MMPD_ASSERT_ALWAYS(a_err_below_v, aclk, aresetn, 17'(err_reg) < v_eff_reg, "boundary error reached block count")
    `MMPD_ASSERT_ALWAYS(a_t_in_range, aclk, aresetn, (t_eff_reg != 14'd0) && (17'(t_eff_reg) <= v_eff_reg), "texel count out of range")
    `MMPD_ASSERT_ALWAYS(a_cnt_below_t, aclk, aresetn, done_reg || (14'(cnt_reg) < t_eff_reg), "texel counter passed texel count")
    `MMPD_ASSERT_NEXT(a_last_closes, aclk, aresetn, emit && emit_last, done_reg && m_valid_reg && m_last_texel, "last texel did not close the window")

endmodule

`default_nettype wire

// ===== tb/sv/tb_minmax_peak_decimator.sv =====
// self-checking testbench of the min/max peak decimator: directed table, then random windows
// depends on mmpd_pkg and minmax_peak_decimator; texels are predicted in-house
// and compared field by field in arrival order
`default_nettype none

module tb_minmax_peak_decimator;
    timeunit 1ns;
    timeprecision 1ps;

    // one analysis block as offered on the s_ channel
    typedef struct packed {
        logic               start;
        logic signed [15:0] min_v;
        logic signed [15:0] max_v;
        logic [15:0]        low_e;
        logic [15:0]        mid_e;
        logic [15:0]        high_e;
    } block_t;

    // one texel as seen on the m_ channel
    typedef struct packed {
        logic [12:0] idx;
        logic [7:0]  min_b;
        logic [7:0]  max_b;
        logic [7:0]  low_b;
        logic [7:0]  mid_b;
        logic [7:0]  high_b;
        logic        last_flag;
    } texel_t;

    typedef enum bit {ROW_BLOCK, ROW_CFG} row_kind_e;
    typedef enum bit {BY_MODEL, BY_HAND} row_check_e;

    typedef struct packed {
        row_kind_e            kind;
        mmpd_pkg::cfg_index_t reg_sel;
        logic [16:0]          reg_val;
        block_t               blk;
        row_check_e           how;
        texel_t               want;
    } dir_row_t;

    // directed table: hand-typed texels only where the bytes are obvious
    localparam dir_row_t DIRECTED_ROWS [28] = '{
        // after reset one block is a whole window: extremes straight through
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b1, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'h0000, 16'h8000},
          BY_HAND, '{13'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 1'b1}},
        // window already complete and no restart: dropped
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh0005, 16'sh0006, 16'h0007, 16'h0008, 16'h0009},
          BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b1, 16'sh7FFF, 16'sh8000, 16'h0000, 16'hFFFF, 16'h0001},
          BY_HAND, '{13'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1}},
        // midscale and exact half-way rounding
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b1, 16'sh0000, 16'sh0000, 16'h8000, 16'h7FFF, 16'h8001},
          BY_HAND, '{13'd0, 8'd128, 8'd128, 8'd128, 8'd127, 8'd128, 1'b1}},
        // seven blocks in three groups, ends after blocks 2, 4 and 7
        '{ROW_CFG, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd7, '0, BY_MODEL, '0},
        '{ROW_CFG, mmpd_pkg::CFG_TEXEL_COUNT, 17'd3, '0, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b1, 16'sh1234, 16'sh2000, 16'h0100, 16'h0200, 16'h0300}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'shF000, 16'sh0F00, 16'hFF00, 16'h0010, 16'h8000}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh0100, 16'sh4000, 16'h0020, 16'hC000, 16'h0040}, BY_MODEL, '0},
        // restart part way through the second group
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b1, 16'shC000, 16'shC100, 16'h1111, 16'h2222, 16'h3333}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh8001, 16'sh7FFE, 16'h00FF, 16'hFF00, 16'h0F0F}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh0000, 16'shFFFF, 16'h5555, 16'hAAAA, 16'h0000}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh3FFF, 16'sh4001, 16'hAAAA, 16'h5555, 16'hFFFF}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh7000, 16'sh7001, 16'h0001, 16'h0002, 16'h0003}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh9000, 16'sh9001, 16'h7FFF, 16'h8000, 16'h8001}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh0123, 16'sh0456, 16'h0789, 16'h0ABC, 16'h0DEF}, BY_MODEL, '0},
        // past the last texel: dropped
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh8000, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, BY_MODEL, '0},
        // zero registers clamp up to one
        '{ROW_CFG, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0, '0, BY_MODEL, '0},
        '{ROW_CFG, mmpd_pkg::CFG_TEXEL_COUNT, 17'd0, '0, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'shFFFF, 16'sh0001, 16'h0064, 16'h00C8, 16'h012C}, BY_MODEL, '0},
        // more texels than blocks: saturated to one block per texel
        '{ROW_CFG, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd4, '0, BY_MODEL, '0},
        '{ROW_CFG, mmpd_pkg::CFG_TEXEL_COUNT, 17'd100, '0, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh8000, 16'sh8000, 16'h0000, 16'h0000, 16'h0000}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'sh00FF, 16'shFF00, 16'h8000, 16'h4000, 16'h2000}, BY_MODEL, '0},
        '{ROW_BLOCK, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd0,
          '{1'b0, 16'shA5A5, 16'sh5A5A, 16'hA5A5, 16'h5A5A, 16'hF00F}, BY_MODEL, '0},
        // all-ones registers clamp to the widest window
        '{ROW_CFG, mmpd_pkg::CFG_VISIBLE_BLOCKS, 17'd131071, '0, BY_MODEL, '0},
        '{ROW_CFG, mmpd_pkg::CFG_TEXEL_COUNT, 17'd16383, '0, BY_MODEL, '0}
    };

    localparam int HOLD_OFF_CYCLES = 80;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    mmpd_pkg::cfg_index_t cfg_index;
    logic [16:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_window_start;
    logic signed [15:0] s_min_value;
    logic signed [15:0] s_max_value;
    logic [15:0] s_low_energy;
    logic [15:0] s_mid_energy;
    logic [15:0] s_high_energy;
    logic        m_valid;
    logic        m_ready;
    logic [12:0] m_texel_index;
    logic [7:0]  m_min_byte;
    logic [7:0]  m_max_byte;
    logic [7:0]  m_low_byte;
    logic [7:0]  m_mid_byte;
    logic [7:0]  m_high_byte;
    logic        m_last_texel;

    minmax_peak_decimator dut (.*);

    // texels predicted but not yet seen, oldest first
    texel_t pending_texels [$];
    int     mismatches = 0;
    int     blocks_taken = 0;

    // pacing controls shared with the receiver
    bit     steady_run = 1'b0;
    int     hold_off_asks = 0;

    // predictor copy of the registers and window state
    logic [16:0]        vis_reg;
    logic [13:0]        tex_reg;
    logic [17:0]        boundary_err;
    logic [12:0]        texel_pos;
    logic signed [15:0] grp_min;
    logic signed [15:0] grp_max;
    logic [15:0]        grp_low;
    logic [15:0]        grp_mid;
    logic [15:0]        grp_high;
    bit                 window_closed;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // blocks per window, zero counts as one
    function automatic int blocks_per_window();
        int v;
        v = vis_reg;
        if (v == 0) v = 1;
        if (v > mmpd_pkg::MAX_BLOCKS) v = mmpd_pkg::MAX_BLOCKS;
        return v;
    endfunction

    // texels per window, never more than there are blocks
    function automatic int texels_per_window();
        int t;
        t = tex_reg;
        if (t == 0) t = 1;
        if (t > mmpd_pkg::MAX_TEXELS) t = mmpd_pkg::MAX_TEXELS;
        if (t > blocks_per_window()) t = blocks_per_window();
        return t;
    endfunction

    function automatic void clear_group();
        grp_min  = 16'sh7FFF;
        grp_max  = 16'sh8000;
        grp_low  = '0;
        grp_mid  = '0;
        grp_high = '0;
    endfunction

    function automatic void open_window();
        boundary_err  = 18'(blocks_per_window() - texels_per_window());
        texel_pos     = '0;
        window_closed = 1'b0;
        clear_group();
    endfunction

    // -1..1 onto 0..255, round half up
    function automatic logic [7:0] amp_to_byte(input logic signed [15:0] m);
        int r;
        r = ((int'(m) + 32768) * 255 + 32768) >> 16;
        if (r > 255) r = 255;
        return 8'(r);
    endfunction

    function automatic logic [7:0] energy_to_byte(input logic [15:0] e);
        int r;
        r = (int'(e) * 255 + 32768) >> 16;
        if (r > 255) r = 255;
        return 8'(r);
    endfunction

    // fold one accepted block into the window; 1 when it closes a group
    function automatic bit fold_block(input block_t b, output texel_t tx);
        int v;
        int t;
        tx = '0;
        blocks_taken++;
        if (b.start) open_window();
        if (window_closed) return 1'b0;
        v = blocks_per_window();
        t = texels_per_window();
        if ($signed(b.min_v) < grp_min) grp_min = b.min_v;
        if ($signed(b.max_v) > grp_max) grp_max = b.max_v;
        if (b.low_e > grp_low) grp_low = b.low_e;
        if (b.mid_e > grp_mid) grp_mid = b.mid_e;
        if (b.high_e > grp_high) grp_high = b.high_e;
        // group still open while the error stays at or above the texel count
        if (int'(boundary_err) >= t) begin
            boundary_err = boundary_err - 18'(t);
            return 1'b0;
        end
        tx.idx       = texel_pos;
        tx.min_b     = amp_to_byte(grp_min);
        tx.max_b     = amp_to_byte(grp_max);
        tx.low_b     = energy_to_byte(grp_low);
        tx.mid_b     = energy_to_byte(grp_mid);
        tx.high_b    = energy_to_byte(grp_high);
        tx.last_flag = (int'(texel_pos) + 1 >= t);
        boundary_err = boundary_err + 18'(v) - 18'(t);
        texel_pos    = texel_pos + 13'd1;
        clear_group();
        if (tx.last_flag) window_closed = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: begin
                return 16'h0000;
            end
            1: begin
                return 16'hFFFF;
            end
            2: begin
                return 16'h8000;
            end
            3: begin
                return 16'h7FFF;
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, predicted %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // stop offering requests until every predicted texel is out, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_texels.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // one request on s_, with random gaps ahead of it outside steady runs
    task automatic offer_block(input block_t b, input bit by_hand, input texel_t hand_tx);
        texel_t tx;
        @(negedge aclk);
        while (!steady_run && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_window_start <= b.start;
        s_min_value    <= b.min_v;
        s_max_value    <= b.max_v;
        s_low_energy   <= b.low_e;
        s_mid_energy   <= b.mid_e;
        s_high_energy  <= b.high_e;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (fold_block(b, tx)) pending_texels.push_back(by_hand ? hand_tx : tx);
    endtask

    // register writes only land on an idle block
    task automatic write_reg(input mmpd_pkg::cfg_index_t sel, input logic [16:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        if (sel == mmpd_pkg::CFG_VISIBLE_BLOCKS) vis_reg = val;
        else tex_reg = val[13:0];
        open_window();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input logic [16:0] vis, input logic [13:0] tex);
        write_reg(mmpd_pkg::CFG_VISIBLE_BLOCKS, vis);
        write_reg(mmpd_pkg::CFG_TEXEL_COUNT, {3'b000, tex});
    endtask

    // receiver: random back-pressure, long hold-off on request, none in steady runs
    initial begin
        int hold_left;
        int asks_seen;
        hold_left = 0;
        asks_seen = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (asks_seen != hold_off_asks) begin
                asks_seen = hold_off_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady_run || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // texel checker, sampled at the rising edge
    always @(posedge aclk) begin
        texel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_texels.size() == 0) begin
                report_mismatch("texel with none predicted", m_texel_index, -1);
            end else begin
                want = pending_texels.pop_front();
                if (m_texel_index !== want.idx)
                    report_mismatch("texel_index", m_texel_index, want.idx);
                if (m_min_byte !== want.min_b)
                    report_mismatch("min_byte", m_min_byte, want.min_b);
                if (m_max_byte !== want.max_b)
                    report_mismatch("max_byte", m_max_byte, want.max_b);
                if (m_low_byte !== want.low_b)
                    report_mismatch("low_byte", m_low_byte, want.low_b);
                if (m_mid_byte !== want.mid_b)
                    report_mismatch("mid_byte", m_mid_byte, want.mid_b);
                if (m_high_byte !== want.high_b)
                    report_mismatch("high_byte", m_high_byte, want.high_b);
                if (m_last_texel !== want.last_flag)
                    report_mismatch("last_texel", m_last_texel, want.last_flag);
            end
        end
    end

    // stimulus: reset, directed table, then random phases of windows
    initial begin
        block_t      blk;
        int          phase;
        int          nitems;
        int          pos;
        int          span;
        logic [16:0] vis_pick;
        logic [13:0] tex_pick;

        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = mmpd_pkg::CFG_VISIBLE_BLOCKS;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_window_start = 1'b0;
        s_min_value    = '0;
        s_max_value    = '0;
        s_low_energy   = '0;
        s_mid_energy   = '0;
        s_high_energy  = '0;

        // both registers come out of reset at one
        vis_reg = 17'd1;
        tex_reg = 14'd1;
        open_window();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                write_reg(DIRECTED_ROWS[i].reg_sel, DIRECTED_ROWS[i].reg_val);
            end else begin
                offer_block(DIRECTED_ROWS[i].blk, DIRECTED_ROWS[i].how == BY_HAND,
                            DIRECTED_ROWS[i].want);
            end
        end

        phase = 0;
        while (blocks_taken < 550) begin
            nitems = $urandom_range(20, 50);
            case (phase)
                0: begin
                    // keep the widest setting left by the table
                end
                1: begin
                    // long stretch with no gaps on either side
                    set_window(17'd12, 14'd5);
                    steady_run = 1'b1;
                    nitems = 80;
                end
                2: begin
                    // a texel per block while the receiver holds off: s_ready must drop
                    set_window(17'd5, 14'd5);
                    hold_off_asks++;
                end
                3: begin
                    set_window(17'd65536, 14'd1);
                end
                4: begin
                    set_window(17'd1, 14'd8192);
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        vis_pick = 17'($urandom_range(0, 131071));
                        tex_pick = 14'($urandom_range(0, 16383));
                    end else begin
                        vis_pick = 17'($urandom_range(1, 24));
                        tex_pick = 14'($urandom_range(0, int'(vis_pick) + 2));
                    end
                    set_window(vis_pick, tex_pick);
                end
            endcase

            pos = 0;
            span = blocks_per_window();
            for (int k = 0; k < nitems; k++) begin
                // mostly whole windows; now and then a stray or missing window_start
                blk.start = (pos == 0);
                if ($urandom_range(0, 99) < 6) blk.start = ~blk.start;
                blk.min_v  = rand_word();
                blk.max_v  = rand_word();
                blk.low_e  = rand_word();
                blk.mid_e  = rand_word();
                blk.high_e = rand_word();
                offer_block(blk, 1'b0, '0);
                pos = blk.start ? 1 : pos + 1;
                // usually restart after a full window, sometimes trail a dropped block
                if (pos >= span && $urandom_range(0, 9) != 0) pos = 0;
                // the sender waits for the output side to empty, once in the widest phase and now and then at random
                if ((phase == 0 && k == nitems / 2) || $urandom_range(0, 49) == 0) drain();
            end
            steady_run = 1'b0;
            phase++;
        end

        drain();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== minmax_peak_decimator.f =====
+incdir+src
src/mmpd_pkg.sv
src/mmpd_quant.sv
src/minmax_peak_decimator.sv
tb/sv/tb_minmax_peak_decimator.sv
